// File: rtl/fprm_pkg.sv
// ----------------------------------------------------------------------------
// fprm_pkg
// Shared types and constants for the frame pacer / rate meter.
// ----------------------------------------------------------------------------
package fprm_pkg;

  localparam int HIST_DEPTH = 300;
  localparam int SLOT_W     = $clog2(HIST_DEPTH);
  localparam int FILL_W     = $clog2(HIST_DEPTH + 1);

  localparam int TS_W       = 63;
  localparam int TIME_W     = 64;
  localparam int RATE_W     = 10;
  localparam int PERIOD_W   = 30;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 30;

  localparam logic [TIME_W-1:0]   ONE_SECOND_NS = 64'd1_000_000_000;
  localparam logic [TIME_W-1:0]   SIGN_BIT      = {1'b1, {(TIME_W-1){1'b0}}};
  localparam logic [RATE_W-1:0]   RATE_RST      = 10'd60;
  localparam logic [PERIOD_W-1:0] PERIOD_RST    = 30'd16_666_666;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_TARGET_RATE  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_PERIOD = 2'd1;

  // request codes
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_FRAME = 1'b1;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_LTS = 2'd2
  } alu_op_t;

  typedef struct packed {
    logic [TIME_W-1:0] sum;
    logic              lt;
  } alu_res_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [TIME_W-1:0] wdata;
    logic              re;
    logic [SLOT_W-1:0] raddr;
  } ring_req_t;

endpackage

// File: rtl/fprm_alu.sv
// ----------------------------------------------------------------------------
// fprm_alu
// Shared 64-bit add / subtract / signed less-than unit.
// ----------------------------------------------------------------------------
module fprm_alu
  import fprm_pkg::*;
(
  input  alu_op_t           op,
  input  logic [TIME_W-1:0] a,
  input  logic [TIME_W-1:0] b,
  output alu_res_t          res
);

  logic [TIME_W-1:0] a_eff;
  logic [TIME_W-1:0] b_eff;
  logic              cin;
  logic [TIME_W:0]   total;

  always_comb begin
    unique case (op)
      OP_ADD: begin
        a_eff = a;
        b_eff = b;
        cin   = 1'b0;
      end
      OP_SUB: begin
        a_eff = a;
        b_eff = ~b;
        cin   = 1'b1;
      end
      OP_LTS: begin
        // signed compare as unsigned compare with flipped sign bits
        a_eff = a ^ SIGN_BIT;
        b_eff = ~(b ^ SIGN_BIT);
        cin   = 1'b1;
      end
      default: begin
        a_eff = a;
        b_eff = b;
        cin   = 1'b0;
      end
    endcase
  end

  assign total   = {1'b0, a_eff} + {1'b0, b_eff} + {{TIME_W{1'b0}}, cin};
  assign res.sum = total[TIME_W-1:0];
  assign res.lt  = ~total[TIME_W];

endmodule

// File: rtl/fprm_ring.sv
// ----------------------------------------------------------------------------
// fprm_ring
// Delta history ring: one write and one registered read per cycle. A fill
// count stands in for the all-zero reset; unwritten entries read as zero.
// ----------------------------------------------------------------------------
module fprm_ring
  import fprm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  ring_req_t         req,
  output logic [TIME_W-1:0] rdata
);

  logic [TIME_W-1:0] mem [HIST_DEPTH];
  logic [TIME_W-1:0] rd_r;
  logic              rvalid_r;
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_r <= mem[req.raddr];
    end
  end

  // writes go in slot order from zero, so entries below the count are live
  always_comb begin
    fill_nxt = fill_r;
    if (req.we && (fill_r != FILL_W'(HIST_DEPTH))) begin
      fill_nxt = fill_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      rvalid_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      if (req.re) begin
        rvalid_r <= (FILL_W'(req.raddr) < fill_r);
      end
    end
  end

  assign rdata = rvalid_r ? rd_r : '0;

endmodule

// File: rtl/frame_pacer_rate_meter_core.sv
// ----------------------------------------------------------------------------
// frame_pacer_rate_meter_core
// Frame pacing clock and recent frame-rate meter.
//
// Input channel (in_valid / in_stall): req_type 0 loads the pacing clock with
// the timestamp and gives no result; req_type 1 is a frame event and gives one
// result word on the out_ channel (out_valid / out_stall).
// A frame event walks back over up to target_rate ring entries (none when
// target_rate is 0): one shared 64-bit adder does the clock update, then
// alternates between adding a ring entry and comparing the running sum
// against one second.
// in_stall stays high for the whole frame event.
// The result sits in an output register; a new word is accepted while it waits,
// and a finished frame event holds until that register is free. out_stall
// backs the block up only in this way.
// Configuration (cfg_valid / cfg_ready, cfg_addr, cfg_data) is always ready:
// index 0 target_rate, index 1 frame_period; other indexes are ignored.
// Reset (rst_n low, synchronous) restores target_rate 60 and frame_period
// 16666666 ns, zeroes the clock and empties the history ring; no clearing
// pass is needed, the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module frame_pacer_rate_meter_core
  import fprm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,

  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_req_type,
  input  logic [TS_W-1:0]         in_timestamp,

  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [TIME_W-1:0] out_frame_delta,
  output logic [RATE_W-1:0]       out_frames_in_second,
  output logic [TS_W-1:0]         out_next_deadline,
  output logic                    out_lag_reset,

  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DELTA = 9'b000000010,
    S_CMP   = 9'b000000100,
    S_NEXT  = 9'b000001000,
    S_LAST  = 9'b000010000,
    S_WRITE = 9'b000100000,
    S_RD    = 9'b001000000,
    S_ACC   = 9'b010000000,
    S_CHK   = 9'b100000000
  } state_t;

  // S_DONE is folded into a flag so the result can wait for the output register
  state_t             state_r, state_nxt;
  logic               done_r, done_nxt;

  logic [RATE_W-1:0]   target_r;
  logic [PERIOD_W-1:0] period_r;

  logic [TIME_W-1:0]  last_r, last_nxt;
  logic [TIME_W-1:0]  next_r, next_nxt;
  logic [TS_W-1:0]    now_r, now_nxt;
  logic [TIME_W-1:0]  delta_r, delta_nxt;
  logic               lag_r, lag_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [SLOT_W-1:0]  idx_r, idx_nxt;
  logic [SLOT_W-1:0]  idx_dec;
  logic [TIME_W-1:0]  sum_r, sum_nxt;
  logic [RATE_W-1:0]  tally_r, tally_nxt;
  logic [RATE_W-1:0]  tally_inc;

  logic               out_valid_r, out_valid_nxt;
  logic [TIME_W-1:0]  out_delta_r;
  logic [RATE_W-1:0]  out_fps_r;
  logic [TS_W-1:0]    out_next_r;
  logic               out_lag_r;
  logic               out_load;

  logic               in_accept;
  alu_op_t            alu_op;
  logic [TIME_W-1:0]  alu_a;
  logic [TIME_W-1:0]  alu_b;
  alu_res_t           alu_res;
  ring_req_t          ring_req;
  logic [TIME_W-1:0]  ring_rdata;

  logic [TIME_W-1:0]  period_x1;
  logic [TIME_W-1:0]  period_x2;

  assign period_x1 = {{(TIME_W-PERIOD_W){1'b0}}, period_r};
  assign period_x2 = {{(TIME_W-PERIOD_W-1){1'b0}}, period_r, 1'b0};

  assign in_stall  = (state_r != S_IDLE) || done_r;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign out_load  = done_r && (!out_valid_r || !out_stall);
  assign idx_dec   = (idx_r == '0) ? SLOT_W'(HIST_DEPTH - 1) : idx_r - 1'b1;
  assign tally_inc = tally_r + 1'b1;

  fprm_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  fprm_ring u_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ring_req),
    .rdata (ring_rdata)
  );

  // operand selection for the shared unit
  always_comb begin
    alu_op = OP_ADD;
    alu_a  = '0;
    alu_b  = '0;
    unique case (state_r)
      S_DELTA: begin
        alu_op = OP_SUB;
        alu_a  = {1'b0, now_r};
        alu_b  = last_r;
      end
      S_CMP: begin
        alu_op = OP_LTS;
        alu_a  = delta_r;
        alu_b  = period_x2;
      end
      S_NEXT: begin
        alu_op = OP_ADD;
        alu_a  = lag_r ? {1'b0, now_r} : last_r;
        alu_b  = lag_r ? period_x1 : period_x2;
      end
      S_LAST: begin
        alu_op = OP_ADD;
        alu_a  = last_r;
        alu_b  = period_x1;
      end
      S_ACC: begin
        alu_op = OP_ADD;
        alu_a  = sum_r;
        alu_b  = ring_rdata;
      end
      S_CHK: begin
        alu_op = OP_LTS;
        alu_a  = ONE_SECOND_NS;
        alu_b  = sum_r;
      end
      S_IDLE, S_WRITE, S_RD: begin
        alu_op = OP_ADD;
      end
      default: begin
        alu_op = OP_ADD;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    done_nxt  = done_r;
    last_nxt  = last_r;
    next_nxt  = next_r;
    now_nxt   = now_r;
    delta_nxt = delta_r;
    lag_nxt   = lag_r;
    slot_nxt  = slot_r;
    idx_nxt   = idx_r;
    sum_nxt   = sum_r;
    tally_nxt = tally_r;

    ring_req.we    = 1'b0;
    ring_req.waddr = slot_r;
    ring_req.wdata = delta_r;
    ring_req.re    = 1'b0;
    ring_req.raddr = idx_r;

    if (out_load) begin
      done_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          now_nxt = in_timestamp;
          if (in_req_type == REQ_START) begin
            last_nxt = {1'b0, in_timestamp};
            next_nxt = {1'b0, in_timestamp};
          end else begin
            state_nxt = S_DELTA;
          end
        end
      end
      S_DELTA: begin
        delta_nxt = alu_res.sum;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        lag_nxt   = ~alu_res.lt;
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        next_nxt  = alu_res.sum;
        state_nxt = S_LAST;
      end
      S_LAST: begin
        last_nxt  = lag_r ? {1'b0, now_r} : alu_res.sum;
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        ring_req.we = 1'b1;
        idx_nxt     = slot_r;
        sum_nxt     = '0;
        tally_nxt   = '0;
        slot_nxt    = (slot_r == SLOT_W'(HIST_DEPTH - 1)) ? '0 : slot_r + 1'b1;
        if (target_r == '0) begin
          state_nxt = S_IDLE;
          done_nxt  = 1'b1;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        ring_req.re    = 1'b1;
        ring_req.raddr = idx_r;
        state_nxt      = S_ACC;
      end
      S_ACC: begin
        sum_nxt   = alu_res.sum;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (alu_res.lt) begin
          // one second exceeded: this entry is not counted
          state_nxt = S_IDLE;
          done_nxt  = 1'b1;
        end else begin
          tally_nxt = tally_inc;
          if (tally_inc == target_r) begin
            state_nxt = S_IDLE;
            done_nxt  = 1'b1;
          end else begin
            idx_nxt        = idx_dec;
            ring_req.re    = 1'b1;
            ring_req.raddr = idx_dec;
            state_nxt      = S_ACC;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
      target_r    <= RATE_RST;
      period_r    <= PERIOD_RST;
      last_r      <= '0;
      next_r      <= '0;
      slot_r      <= '0;
      idx_r       <= '0;
      tally_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
      last_r      <= last_nxt;
      next_r      <= next_nxt;
      slot_r      <= slot_nxt;
      idx_r       <= idx_nxt;
      tally_r     <= tally_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_addr == REG_TARGET_RATE) begin
          target_r <= cfg_data[RATE_W-1:0];
        end else if (cfg_addr == REG_FRAME_PERIOD) begin
          period_r <= cfg_data[PERIOD_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    now_r   <= now_nxt;
    delta_r <= delta_nxt;
    lag_r   <= lag_nxt;
    sum_r   <= sum_nxt;
    if (out_load) begin
      out_delta_r <= delta_r;
      out_fps_r   <= tally_r;
      out_next_r  <= next_r[TS_W-1:0];
      out_lag_r   <= lag_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_frame_delta      = out_delta_r;
  assign out_frames_in_second = out_fps_r;
  assign out_next_deadline    = out_next_r;
  assign out_lag_reset        = out_lag_r;

  // ------------------------------------------------------------------------
  // assertions
  // ------------------------------------------------------------------------
  a_state_onehot : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_tally_below_cap : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK) |-> (tally_r < target_r))
    else $error("walk counted past target_rate");

  a_idx_in_ring : assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r < SLOT_W'(HIST_DEPTH)) && (slot_r < SLOT_W'(HIST_DEPTH)))
    else $error("ring index out of range");

  a_done_delivers : assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid && !done_r))
    else $error("finished frame event not presented");

  a_busy_while_walking : assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r != S_IDLE) || done_r) |-> in_stall)
    else $error("input taken while frame event in progress");

endmodule

// File: tb/fprm_checker.sv
// ----------------------------------------------------------------------------
// fprm_checker
// Watches the input, result and register channels of the frame pacer, keeps
// its own pacing clock, delta ring and rate meter, and compares every result
// word field by field with the oldest expected word.
// ----------------------------------------------------------------------------
module fprm_checker
  import fprm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,

  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic                     in_req_type,
  input  logic [TS_W-1:0]          in_timestamp,

  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [TIME_W-1:0] out_frame_delta,
  input  logic [RATE_W-1:0]        out_frames_in_second,
  input  logic [TS_W-1:0]          out_next_deadline,
  input  logic                     out_lag_reset,

  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [CFG_DATA_W-1:0]    cfg_data,

  output int                       fail_count,
  output int                       pending_words
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [TIME_W-1:0] delta;
    logic [RATE_W-1:0] rate_count;
    logic [TS_W-1:0]   deadline;
    logic              lag;
  } pace_word_t;

  logic [TIME_W-1:0]   last_t;
  logic [TIME_W-1:0]   next_t;
  logic [TIME_W-1:0]   delta_ring [HIST_DEPTH];
  int unsigned         wr_slot;
  logic [RATE_W-1:0]   rate_cap;
  logic [PERIOD_W-1:0] period_ns;
  pace_word_t          pace_q [$];

  task automatic report_mismatch(input string what, input logic [TIME_W-1:0] got,
                                 input logic [TIME_W-1:0] want);
    $display("%0t ns mismatch %s: got %h expected %h", $time, what, got, want);
    fail_count++;
  endtask

  // walk back from the newest delta until the running sum passes one second or the rate cap is reached
  function automatic logic [RATE_W-1:0] count_recent(input int unsigned from_slot);
    int unsigned       idx;
    int unsigned       tally;
    logic [TIME_W-1:0] sum;
    logic              over;
    idx   = from_slot;
    tally = 0;
    sum   = '0;
    over  = 1'b0;
    while (!over && tally < rate_cap) begin
      sum = sum + delta_ring[idx];
      if ($signed(sum) > $signed(ONE_SECOND_NS)) begin
        over = 1'b1;
      end else begin
        idx = (idx == 0) ? HIST_DEPTH - 1 : idx - 1;
        tally++;
      end
    end
    return RATE_W'(tally);
  endfunction

  function automatic pace_word_t pace_frame(input logic [TS_W-1:0] ts);
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] twice;
    pace_word_t        w;
    now     = {1'b0, ts};
    twice   = {{(TIME_W-PERIOD_W){1'b0}}, period_ns} << 1;
    w.delta = now - last_t;
    if ($signed(w.delta) < $signed(twice)) begin
      next_t = last_t + twice;
      last_t = last_t + period_ns;
      w.lag  = 1'b0;
    end else begin
      next_t = now + period_ns;
      last_t = now;
      w.lag  = 1'b1;
    end
    delta_ring[wr_slot] = w.delta;
    w.rate_count = count_recent(wr_slot);
    w.deadline   = next_t[TS_W-1:0];
    wr_slot      = (wr_slot == HIST_DEPTH - 1) ? 0 : wr_slot + 1;
    return w;
  endfunction

  always @(posedge clk) begin : track
    pace_word_t want;
    int         i;
    if (!rst_n) begin
      last_t    = '0;
      next_t    = '0;
      wr_slot   = 0;
      rate_cap  = RATE_RST;
      period_ns = PERIOD_RST;
      for (i = 0; i < HIST_DEPTH; i++)
        delta_ring[i] = '0;
      pace_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          REG_TARGET_RATE:  rate_cap  = cfg_data[RATE_W-1:0];
          REG_FRAME_PERIOD: period_ns = cfg_data[PERIOD_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        if (pace_q.size() == 0) begin
          report_mismatch("result word with none expected", out_frame_delta, '0);
        end else begin
          want = pace_q.pop_front();
          if (out_frame_delta !== want.delta)
            report_mismatch("frame_delta", out_frame_delta, want.delta);
          if (out_frames_in_second !== want.rate_count)
            report_mismatch("frames_in_second", TIME_W'(out_frames_in_second),
                            TIME_W'(want.rate_count));
          if (out_next_deadline !== want.deadline)
            report_mismatch("next_deadline", TIME_W'(out_next_deadline),
                            TIME_W'(want.deadline));
          if (out_lag_reset !== want.lag)
            report_mismatch("lag_reset", TIME_W'(out_lag_reset), TIME_W'(want.lag));
        end
      end

      if (in_valid && !in_stall) begin
        if (in_req_type == REQ_START) begin
          last_t = {1'b0, in_timestamp};
          next_t = {1'b0, in_timestamp};
        end else begin
          pace_q.push_back(pace_frame(in_timestamp));
        end
      end
    end
    pending_words <= pace_q.size();
  end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the frame pacer / rate meter: directed corner words, a
// back-pressure pass and random pacing streams over several register
// settings, with random idling on both channels. The checker beside the
// block does the prediction; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import fprm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED  = 2'd3;
  localparam logic [TS_W-1:0]       TS_MAX      = '1;
  localparam int                    QUIET_LIMIT = 20000;
  localparam int                    HOLD_LEN    = 500;
  localparam int                    TAIL_CYCLES = 2 * 1023 + 16;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic                     in_req_type;
  logic [TS_W-1:0]          in_timestamp;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [TIME_W-1:0] out_frame_delta;
  logic [RATE_W-1:0]        out_frames_in_second;
  logic [TS_W-1:0]          out_next_deadline;
  logic                     out_lag_reset;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_ADDR_W-1:0]    cfg_addr;
  logic [CFG_DATA_W-1:0]    cfg_data;

  int                  fail_count;
  int                  pending_words;
  bit                  send_idle;
  bit                  recv_idle;
  int                  hold_kicks;
  logic [PERIOD_W-1:0] cur_period;

  frame_pacer_rate_meter_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_req_type          (in_req_type),
    .in_timestamp         (in_timestamp),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_frame_delta      (out_frame_delta),
    .out_frames_in_second (out_frames_in_second),
    .out_next_deadline    (out_next_deadline),
    .out_lag_reset        (out_lag_reset),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_addr             (cfg_addr),
    .cfg_data             (cfg_data)
  );

  fprm_checker checker_i (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_req_type          (in_req_type),
    .in_timestamp         (in_timestamp),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_frame_delta      (out_frame_delta),
    .out_frames_in_second (out_frames_in_second),
    .out_next_deadline    (out_next_deadline),
    .out_lag_reset        (out_lag_reset),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_addr             (cfg_addr),
    .cfg_data             (cfg_data),
    .fail_count           (fail_count),
    .pending_words        (pending_words)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side: random stall, or a long hold-off when asked for one
  initial begin : receiver
    int seen;
    seen = 0;
    forever begin
      if (hold_kicks != seen) begin
        seen = hold_kicks;
        out_stall <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
      end else begin
        out_stall <= recv_idle && ($urandom_range(99) < 34);
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [TS_W-1:0] rand_ts();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[TS_W-1:0];
  endfunction

  task automatic send_word(input logic req, input logic [TS_W-1:0] ts);
    while (send_idle && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_req_type  <= req;
    in_timestamp <= ts;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [RATE_W-1:0] rate, input logic [PERIOD_W-1:0] period);
    write_reg(REG_TARGET_RATE, CFG_DATA_W'(rate));
    write_reg(REG_FRAME_PERIOD, CFG_DATA_W'(period));
    cur_period = period;
  endtask

  // wait for every expected word
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
    repeat (4) @(posedge clk);
  endtask

  // mostly well paced frames after a start, with lags, early frames and noise
  task automatic run_stream(input int n_words);
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] p;
    int                k;
    int                pick;
    p = {{(TIME_W-PERIOD_W){1'b0}}, cur_period};
    t = {1'b0, rand_ts()};
    send_word(REQ_START, t[TS_W-1:0]);
    for (k = 1; k < n_words; k++) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        send_word($urandom_range(1) != 0, rand_ts());
      end else if (pick < 9) begin
        t = {1'b0, rand_ts()};
        send_word(REQ_START, t[TS_W-1:0]);
      end else begin
        if (pick < 17)
          t = t + p * $urandom_range(2, 5) + $urandom_range(1000);
        else if (pick < 21)
          t = t - $urandom_range(5000);
        else
          t = t + p - (p >> 3) + $urandom_range(cur_period >> 2);
        send_word(REQ_FRAME, t[TS_W-1:0]);
      end
    end
  endtask

  initial begin : stimulus
    int ph;
    int k;
    logic [PERIOD_W-1:0] per;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_req_type  <= REQ_START;
    in_timestamp <= '0;
    cfg_valid    <= 1'b0;
    cfg_addr     <= REG_TARGET_RATE;
    cfg_data     <= '0;
    send_idle    = 1'b1;
    recv_idle    = 1'b1;
    hold_kicks   = 0;
    cur_period   = PERIOD_RST;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: frame before any start, extreme timestamps, lag and early frames
    send_word(REQ_FRAME, 63'd5);
    send_word(REQ_FRAME, TS_MAX);
    send_word(REQ_START, '0);
    send_word(REQ_FRAME, 63'd16_666_666);
    send_word(REQ_FRAME, 63'(3 * 16_666_666 - 1));
    send_word(REQ_FRAME, 63'(5 * 16_666_666));
    send_word(REQ_FRAME, 63'd2);
    send_word(REQ_START, TS_MAX);
    send_word(REQ_FRAME, '0);
    send_word(REQ_FRAME, TS_MAX);

    // zero rate cap, widest period
    drain();
    set_config('0, '1);
    send_word(REQ_START, 63'd100);
    send_word(REQ_FRAME, 63'd100 + 63'h3FFF_FFFF);
    send_word(REQ_FRAME, 63'd100 + 63'h7FFF_FFFE);

    // zero period: only a negative delta is on time; largest cap walks the ring
    drain();
    set_config('1, '0);
    send_word(REQ_START, 63'd10);
    send_word(REQ_FRAME, 63'd10);
    send_word(REQ_FRAME, 63'd5);
    send_word(REQ_FRAME, 63'd12);

    // cap above the ring depth rereads entries; unused index has no effect
    drain();
    write_reg(REG_UNUSED, '1);
    set_config(10'd341, 30'd1000);
    send_word(REQ_START, '0);
    for (k = 1; k <= 3; k++)
      send_word(REQ_FRAME, 63'(k * 1000));

    // back-pressure: receiver holds off while frames keep coming
    drain();
    set_config(10'd3, 30'd1000);
    send_idle = 1'b0;
    recv_idle = 1'b0;
    hold_kicks++;
    send_word(REQ_START, '0);
    for (k = 1; k <= 12; k++)
      send_word(REQ_FRAME, 63'(k * 1000));
    drain();

    for (ph = 0; ph < 8; ph++) begin
      drain();
      case ($urandom_range(3))
        0:       per = PERIOD_W'($urandom_range(1000, 100_000));
        1:       per = PERIOD_W'($urandom_range(1_000_000, 40_000_000));
        2:       per = 30'd16_666_666;
        default: per = PERIOD_W'($urandom_range(1, 30'h3FFF_FFFF));
      endcase
      case (ph)
        2:       set_config('0, per);
        4:       set_config('1, 30'd50_000_000);
        6:       set_config(RATE_W'($urandom_range(1, 120)), '0);
        default: set_config(RATE_W'($urandom_range(1, 120)), per);
      endcase
      send_idle = (ph != 5);
      recv_idle = (ph != 5);
      run_stream(68);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
